// ===== rtl/k_queues_shared_buffer_top_macros.svh =====
// Assertion macros shared by the RTL of the shared-buffer queue block.
// Included by the modules that carry concurrent assertions; depends on nothing.
`ifndef K_QUEUES_SHARED_BUFFER_TOP_MACROS_SVH
`define K_QUEUES_SHARED_BUFFER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define KSB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("k_queues_shared_buffer: assertion failed");

// Next-cycle implication, checked outside reset.
`define KSB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("k_queues_shared_buffer: assertion failed");

`endif

// ===== rtl/ksb_pkg.sv =====
// Package of the shared-buffer queue block: widths, codes and state type.
// Used by the interfaces and the top level; depends on nothing.
package ksb_pkg;

    // Default sizes of the slot store and the queue table.
    localparam int SLOT_COUNT_DEF  = 64;
    localparam int QUEUE_COUNT_DEF = 8;

    // Fixed payload widths.
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;

    // Command codes.
    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    // Status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    // Controller states.
    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_LOOK,
        S_LINK,
        S_POP,
        S_HOLD
    } t_state;

endpackage

// ===== rtl/ksb_cmd_if.sv =====
// Command channel of the shared-buffer queue block: valid/ready plus payload.
// Depends on ksb_pkg for widths.
interface ksb_cmd_if #(
    parameter int QUEUE_COUNT = ksb_pkg::QUEUE_COUNT_DEF
);
    localparam int QW = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;

    logic                              valid;
    logic                              ready;
    logic                              command;
    logic [QW-1:0]                     queue_index;
    logic signed [ksb_pkg::DATA_W-1:0] data_in;

    modport source (output valid, command, queue_index, data_in, input ready);
    modport sink   (input valid, command, queue_index, data_in, output ready);
endinterface

// Response channel of the shared-buffer queue block: valid/ready plus payload.
// Depends on ksb_pkg for widths.
interface ksb_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [ksb_pkg::STATUS_W-1:0]        status;
    logic signed [ksb_pkg::DATA_W-1:0]   data_out;

    modport source (output valid, status, data_out, input ready);
    modport sink   (input valid, status, data_out, output ready);
endinterface

// ===== rtl/ksb_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; used for the slot store and the queue table.
module ksb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered; a same-address write returns old data.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/k_queues_shared_buffer_top.sv =====
// Top level of the shared-buffer queue block: controller, slot store, queue table.
// Depends on ksb_pkg, ksb_cmd_if, ksb_rsp_if, ksb_ram and the assertion macros.
//
// Usage: QUEUE_COUNT FIFO queues share SLOT_COUNT word slots kept on linked lists.
// Command channel i_cmd carries command (enqueue or dequeue), queue_index and
// data_in; a word is taken when valid and ready are both high. Response channel
// o_rsp carries status (ok, full, empty) and data_out, one word per command.
// Each command reads the queue table and the slot store, then, unless it reports full or empty, writes back.
// A full or empty report and an enqueue to an empty queue load the response
// register from the lookup step S_LOOK; an enqueue behind a tail and a dequeue
// load it from a further step, S_LINK or S_POP, since the slot store is read a
// second time at an address from the queue table, through its single read port.
// Commands are handled one at a time; a new command is taken as soon as the
// previous one has loaded its response, even while that response waits.
// After reset the block sweeps both memories to build the free list and empty
// the queues, with ready low.
// If the receiver stalls, the response register holds, the next command is
// still taken and then waits with its result until the register frees.
`include "k_queues_shared_buffer_top_macros.svh"

module k_queues_shared_buffer_top #(
    parameter int SLOT_COUNT  = ksb_pkg::SLOT_COUNT_DEF,
    parameter int QUEUE_COUNT = ksb_pkg::QUEUE_COUNT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ksb_cmd_if.sink    i_cmd,
    ksb_rsp_if.source  o_rsp
);

    localparam int DW       = ksb_pkg::DATA_W;
    localparam int SW       = ksb_pkg::STATUS_W;
    localparam int LW       = $clog2(SLOT_COUNT + 1);
    localparam int SAW      = $clog2(SLOT_COUNT);
    localparam int QAW      = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
    localparam int INIT_LEN = (SLOT_COUNT > QUEUE_COUNT) ? SLOT_COUNT : QUEUE_COUNT;
    localparam int IW       = $clog2(INIT_LEN);
    localparam logic [LW-1:0] NONE = LW'(SLOT_COUNT);

    // Link codes at or above SLOT_COUNT mean none.
    function automatic logic f_is_slot(input logic [LW-1:0] s);
        return s < NONE;
    endfunction

    // Registers.
    ksb_pkg::t_state    r_state, n_state;
    logic [IW-1:0]      r_init_cnt, n_init_cnt;
    logic [LW-1:0]      r_free_head, n_free_head;
    logic               r_cmd, n_cmd;
    logic [QAW-1:0]     r_q, n_q;
    logic [DW-1:0]      r_data, n_data;
    logic [LW-1:0]      r_idx, n_idx;
    logic [LW-1:0]      r_tail, n_tail;
    logic [SW-1:0]      r_res_status, n_res_status;
    logic [DW-1:0]      r_res_data, n_res_data;
    logic               r_out_valid, n_out_valid;
    logic [SW-1:0]      r_out_status, n_out_status;
    logic [DW-1:0]      r_out_data, n_out_data;

    // Memory ports.
    logic               slot_we;
    logic [SAW-1:0]     slot_waddr, slot_raddr;
    logic [LW+DW-1:0]   slot_wdata, slot_rdata;
    logic               queue_we;
    logic [QAW-1:0]     queue_waddr, queue_raddr;
    logic [2*LW-1:0]    queue_wdata, queue_rdata;

    // Decoded read data and helpers.
    logic [LW-1:0]      rd_head, rd_tail, rd_link;
    logic [DW-1:0]      rd_word;
    logic               q_ok, link_tail, can_emit, accept;
    logic               fin;
    logic [SW-1:0]      fin_status;
    logic [DW-1:0]      fin_data;

    assign rd_head   = queue_rdata[2*LW-1:LW];
    assign rd_tail   = queue_rdata[LW-1:0];
    assign rd_link   = slot_rdata[LW+DW-1:DW];
    assign rd_word   = slot_rdata[DW-1:0];
    assign q_ok      = {1'b0, r_q} < (QAW+1)'(QUEUE_COUNT);
    assign link_tail = f_is_slot(rd_head) && f_is_slot(rd_tail);
    assign can_emit  = !r_out_valid || o_rsp.ready;
    assign accept    = i_cmd.valid && i_cmd.ready;

    assign i_cmd.ready    = (r_state == ksb_pkg::S_IDLE);
    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.status   = r_out_status;
    assign o_rsp.data_out = r_out_data;

    // Slot store: {link, word} per slot.
    ksb_ram #(
        .WIDTH (LW + DW),
        .DEPTH (SLOT_COUNT)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_waddr),
        .i_wdata (slot_wdata),
        .i_raddr (slot_raddr),
        .o_rdata (slot_rdata)
    );

    // Queue table: {head, tail} per queue.
    ksb_ram #(
        .WIDTH (2 * LW),
        .DEPTH (QUEUE_COUNT)
    ) u_queue_ram (
        .i_clk   (i_clk),
        .i_we    (queue_we),
        .i_waddr (queue_waddr),
        .i_wdata (queue_wdata),
        .i_raddr (queue_raddr),
        .o_rdata (queue_rdata)
    );

    // State and control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ksb_pkg::S_INIT;
            r_init_cnt  <= '0;
            r_free_head <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_init_cnt  <= n_init_cnt;
            r_free_head <= n_free_head;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_q          <= n_q;
        r_data       <= n_data;
        r_idx        <= n_idx;
        r_tail       <= n_tail;
        r_res_status <= n_res_status;
        r_res_data   <= n_res_data;
        r_out_status <= n_out_status;
        r_out_data   <= n_out_data;
    end

    // Next state, memory accesses and results.
    always_comb begin
        n_state      = r_state;
        n_init_cnt   = r_init_cnt;
        n_free_head  = r_free_head;
        n_cmd        = r_cmd;
        n_q          = r_q;
        n_data       = r_data;
        n_idx        = r_idx;
        n_tail       = r_tail;
        n_res_status = r_res_status;
        n_res_data   = r_res_data;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_status = r_out_status;
        n_out_data   = r_out_data;

        slot_we      = 1'b0;
        slot_waddr   = r_idx[SAW-1:0];
        slot_wdata   = {NONE, r_data};
        slot_raddr   = r_free_head[SAW-1:0];
        queue_we     = 1'b0;
        queue_waddr  = r_q;
        queue_wdata  = {NONE, NONE};
        queue_raddr  = QAW'(i_cmd.queue_index);

        fin          = 1'b0;
        fin_status   = ksb_pkg::STATUS_OK;
        fin_data     = '0;

        case (r_state)
            // Sweep: slot i links to i+1, every queue empty.
            ksb_pkg::S_INIT: begin
                slot_we     = {1'b0, r_init_cnt} < (IW+1)'(SLOT_COUNT);
                slot_waddr  = r_init_cnt[SAW-1:0];
                slot_wdata  = {LW'(r_init_cnt) + LW'(1), DW'(0)};
                queue_we    = {1'b0, r_init_cnt} < (IW+1)'(QUEUE_COUNT);
                queue_waddr = r_init_cnt[QAW-1:0];
                queue_wdata = {NONE, NONE};
                if (r_init_cnt == IW'(INIT_LEN - 1)) begin
                    n_state = ksb_pkg::S_IDLE;
                end else begin
                    n_init_cnt = r_init_cnt + IW'(1);
                end
            end

            // Take a command; read its queue entry and the free-list head slot.
            ksb_pkg::S_IDLE: begin
                if (accept) begin
                    n_cmd   = i_cmd.command;
                    n_q     = QAW'(i_cmd.queue_index);
                    n_data  = i_cmd.data_in;
                    n_state = ksb_pkg::S_LOOK;
                end
            end

            // Queue entry and free slot are on the read ports.
            ksb_pkg::S_LOOK: begin
                if (r_cmd == ksb_pkg::CMD_ENQ) begin
                    if (!q_ok || !f_is_slot(r_free_head)) begin
                        fin        = 1'b1;
                        fin_status = ksb_pkg::STATUS_FULL;
                    end else begin
                        slot_we     = 1'b1;
                        slot_waddr  = r_free_head[SAW-1:0];
                        slot_wdata  = {NONE, r_data};
                        queue_we    = 1'b1;
                        queue_wdata = {(link_tail ? rd_head : r_free_head), r_free_head};
                        n_free_head = rd_link;
                        n_idx       = r_free_head;
                        n_tail      = rd_tail;
                        if (link_tail) begin
                            slot_raddr = rd_tail[SAW-1:0];
                            n_state    = ksb_pkg::S_LINK;
                        end else begin
                            fin = 1'b1;
                        end
                    end
                end else begin
                    if (!q_ok || !f_is_slot(rd_head)) begin
                        fin        = 1'b1;
                        fin_status = ksb_pkg::STATUS_EMPTY;
                        fin_data   = '1;
                    end else begin
                        slot_raddr = rd_head[SAW-1:0];
                        n_idx      = rd_head;
                        n_tail     = rd_tail;
                        n_state    = ksb_pkg::S_POP;
                    end
                end
            end

            // Old tail slot is on the read port: point its link at the new slot.
            ksb_pkg::S_LINK: begin
                slot_we    = 1'b1;
                slot_waddr = r_tail[SAW-1:0];
                slot_wdata = {r_idx, rd_word};
                fin        = 1'b1;
            end

            // Head slot is on the read port: unlink it and push it on the free list.
            ksb_pkg::S_POP: begin
                queue_we    = 1'b1;
                queue_wdata = f_is_slot(rd_link) ? {rd_link, r_tail} : {NONE, NONE};
                slot_we     = 1'b1;
                slot_waddr  = r_idx[SAW-1:0];
                slot_wdata  = {r_free_head, rd_word};
                n_free_head = r_idx;
                fin         = 1'b1;
                fin_data    = rd_word;
            end

            // Result waits for the response register.
            ksb_pkg::S_HOLD: begin
                if (can_emit) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_data   = r_res_data;
                    n_state      = ksb_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = ksb_pkg::S_IDLE;
            end
        endcase

        // A finished command loads the response register or parks its result.
        if (fin) begin
            n_res_status = fin_status;
            n_res_data   = fin_data;
            if (can_emit) begin
                n_out_valid  = 1'b1;
                n_out_status = fin_status;
                n_out_data   = fin_data;
                n_state      = ksb_pkg::S_IDLE;
            end else begin
                n_state = ksb_pkg::S_HOLD;
            end
        end
    end

    // An accepted word always goes on to the lookup step.
    `KSB_ASSERT_NEXT(a_accept_to_look, i_clk, i_rst_n, accept, r_state == ksb_pkg::S_LOOK)
    // A parked result only exists while the response register is occupied.
    `KSB_ASSERT_IMPL(a_hold_out_busy, i_clk, i_rst_n, r_state == ksb_pkg::S_HOLD, r_out_valid)
    // The relinked tail is never the slot just taken from the free list.
    `KSB_ASSERT_IMPL(a_link_not_self, i_clk, i_rst_n, r_state == ksb_pkg::S_LINK, r_tail != r_idx)
    // The free-list head is a slot or the none code, nothing beyond.
    `KSB_ASSERT_IMPL(a_free_head_range, i_clk, i_rst_n, r_state != ksb_pkg::S_INIT, r_free_head <= NONE)

endmodule

// ===== sim/tb_k_queues_shared_buffer_top.sv =====
`timescale 1ns / 1ps
// Testbench of the shared-buffer queue block: a linked-list predictor and a scoreboard
// check every response word, with random gaps on the command side and stalls on responses.
// Depends on ksb_pkg, ksb_cmd_if, ksb_rsp_if and k_queues_shared_buffer_top.

// One expected response word.
typedef struct packed {
    logic [ksb_pkg::STATUS_W-1:0] status;
    logic [ksb_pkg::DATA_W-1:0]   data;
} t_reply;

// Mirrors the slot store, its links and the queue table, and keeps the replies still due.
class shared_queue_ledger;
    localparam int SLOTS  = ksb_pkg::SLOT_COUNT_DEF;
    localparam int QUEUES = ksb_pkg::QUEUE_COUNT_DEF;
    localparam int LINK_W = $clog2(SLOTS) + 1;
    localparam logic [LINK_W-1:0] NO_SLOT = LINK_W'(SLOTS);

    logic [ksb_pkg::DATA_W-1:0] slot_word [SLOTS];
    logic [LINK_W-1:0]          slot_next [SLOTS];
    logic [LINK_W-1:0]          head_of   [QUEUES];
    logic [LINK_W-1:0]          tail_of   [QUEUES];
    logic [LINK_W-1:0]          free_top;
    t_reply                     replies_due [$];
    int                         errors;

    function new();
        // After reset every slot is free and chained in order; all queues are empty.
        for (int i = 0; i < SLOTS; i++) begin
            slot_word[i] = '0;
            slot_next[i] = LINK_W'(i + 1);
        end
        for (int i = 0; i < QUEUES; i++) begin
            head_of[i] = NO_SLOT;
            tail_of[i] = NO_SLOT;
        end
        free_top = '0;
        errors   = 0;
    endfunction

    function int outstanding();
        return replies_due.size();
    endfunction

    task report(input string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    // Applies one accepted command word to the mirrored lists and queues its reply.
    function void note_command(input logic cmd, input int q, input logic [31:0] word);
        t_reply            r;
        logic [LINK_W-1:0] s;
        logic [LINK_W-1:0] nxt;
        r.status = ksb_pkg::STATUS_OK;
        r.data   = '0;
        if (cmd == ksb_pkg::CMD_ENQ) begin
            s = free_top;
            if (q >= QUEUES || s >= SLOTS) begin
                r.status = ksb_pkg::STATUS_FULL;
            end else begin
                free_top = slot_next[s];
                if (head_of[q] >= SLOTS || tail_of[q] >= SLOTS) begin
                    head_of[q] = s;
                end else begin
                    slot_next[tail_of[q]] = s;
                end
                slot_next[s] = NO_SLOT;
                tail_of[q]   = s;
                slot_word[s] = word;
            end
        end else begin
            s = (q < QUEUES) ? head_of[q] : NO_SLOT;
            if (s >= SLOTS) begin
                r.status = ksb_pkg::STATUS_EMPTY;
                r.data   = '1;
            end else begin
                nxt = slot_next[s];
                if (nxt >= SLOTS) begin
                    head_of[q] = NO_SLOT;
                    tail_of[q] = NO_SLOT;
                end else begin
                    head_of[q] = nxt;
                end
                slot_next[s] = free_top;
                free_top     = s;
                r.data       = slot_word[s];
            end
        end
        replies_due.insert(replies_due.size(), r);
    endfunction

    // Compares one accepted response word with the oldest reply due.
    task check_reply(input logic [ksb_pkg::STATUS_W-1:0] status,
                     input logic [ksb_pkg::DATA_W-1:0] data);
        t_reply r;
        if (replies_due.size() == 0) begin
            report($sformatf("response status %0d data %h with no command pending",
                             status, data));
        end else begin
            r = replies_due[0];
            replies_due.delete(0);
            if (status !== r.status)
                report($sformatf("status %0d, expected %0d", status, r.status));
            if (data !== r.data)
                report($sformatf("data_out %h, expected %h", data, r.data));
        end
    endtask
endclass

module tb_k_queues_shared_buffer_top;

    localparam int CLK_PERIOD   = 10;
    localparam int QUEUES       = ksb_pkg::QUEUE_COUNT_DEF;
    localparam int QUEUE_W      = $clog2(QUEUES);
    localparam int RANDOM_ITEMS = 1600;
    localparam int SETTLE       = 16;
    localparam int CYCLE_LIMIT  = 200000;

    // Traffic mixes of the random phases.
    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_EVEN,
        MIX_FEW_QUEUES
    } t_mix;

    logic i_clk;
    logic i_rst_n;
    int   items_sent;
    int   cycle_count;

    shared_queue_ledger ledger;

    ksb_cmd_if #(.QUEUE_COUNT(QUEUES)) cmd_if ();
    ksb_rsp_if                         rsp_if ();

    k_queues_shared_buffer_top #(
        .SLOT_COUNT  (ksb_pkg::SLOT_COUNT_DEF),
        .QUEUE_COUNT (QUEUES)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_rsp   (rsp_if)
    );

    // Free-running clock.
    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Presents one command word from a falling edge and holds it until accepted.
    task automatic send_cmd(input logic cmd, input logic [QUEUE_W-1:0] q,
                            input logic [ksb_pkg::DATA_W-1:0] word);
        cmd_if.valid       = 1'b1;
        cmd_if.command     = cmd;
        cmd_if.queue_index = q;
        cmd_if.data_in     = word;
        do begin
            @(posedge i_clk);
        end while (cmd_if.ready !== 1'b1);
        ledger.note_command(cmd, int'(q), word);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Holds the command side idle until every reply has come back.
    task automatic wait_all_replies();
        cmd_if.valid = 1'b0;
        while (ledger.outstanding() != 0) @(negedge i_clk);
    endtask

    // One random phase: bursts of commands of the given mix, with or without gaps.
    task automatic run_phase(input t_mix mix, input int count);
        int                          enq_pct;
        int                          qlo;
        int                          qhi;
        int                          burst;
        int                          gap;
        bit                          gapless;
        logic                        cmd;
        logic [ksb_pkg::DATA_W-1:0]  word;
        enq_pct = 50;
        qlo     = 0;
        qhi     = QUEUES - 1;
        gapless = ($urandom_range(0, 3) == 0);
        case (mix)
            MIX_FILL:  enq_pct = 85;
            MIX_DRAIN: enq_pct = 20;
            MIX_EVEN:  enq_pct = 50;
            MIX_FEW_QUEUES: begin
                enq_pct = 55;
                qlo     = $urandom_range(0, QUEUES - 2);
                qhi     = qlo + $urandom_range(0, 1);
            end
            default: enq_pct = 50;
        endcase
        while (count > 0) begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && count > 0) begin
                cmd = ($urandom_range(0, 99) < enq_pct) ? ksb_pkg::CMD_ENQ : ksb_pkg::CMD_DEQ;
                // Now and then an extreme word instead of a random one.
                case ($urandom_range(0, 15))
                    0:       word = 32'h8000_0000;
                    1:       word = 32'h7FFF_FFFF;
                    2:       word = 32'h0000_0000;
                    3:       word = 32'hFFFF_FFFF;
                    default: word = $urandom();
                endcase
                send_cmd(cmd, QUEUE_W'($urandom_range(qlo, qhi)), word);
                burst--;
                count--;
            end
            gap = gapless ? 0 : $urandom_range(0, 5);
            if (gap > 0) begin
                cmd_if.valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
    endtask

    // Response side: stalls on a pattern of its own, chosen anew at random for each span.
    initial begin
        int style;
        int span;
        rsp_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            style = $urandom_range(0, 3);
            span  = $urandom_range(10, 60);
            for (int i = 0; i < span; i++) begin
                @(negedge i_clk);
                case (style)
                    0:       rsp_if.ready = 1'b1;
                    1:       rsp_if.ready = 1'($urandom_range(0, 1));
                    2:       rsp_if.ready = ($urandom_range(0, 7) != 0);
                    default: rsp_if.ready = ((i % 12) < 4);
                endcase
            end
        end
    end

    // Every accepted response word is checked at the edge that takes it.
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready)
            ledger.check_reply(rsp_if.status, rsp_if.data_out);
    end

    // Watchdog on the whole run.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // Reset, directed commands, then random phases.
    initial begin
        t_mix mix;
        ledger             = new();
        items_sent         = 0;
        i_rst_n            = 1'b0;
        cmd_if.valid       = 1'b0;
        cmd_if.command     = ksb_pkg::CMD_ENQ;
        cmd_if.queue_index = '0;
        cmd_if.data_in     = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Empty queue straight after reset, then extreme words on the outer queues.
        send_cmd(ksb_pkg::CMD_DEQ, 3'd0, $urandom());
        send_cmd(ksb_pkg::CMD_ENQ, 3'd0, 32'h8000_0000);
        send_cmd(ksb_pkg::CMD_ENQ, 3'd0, 32'h7FFF_FFFF);
        send_cmd(ksb_pkg::CMD_ENQ, 3'd7, 32'h0000_0000);
        send_cmd(ksb_pkg::CMD_ENQ, 3'd7, 32'hFFFF_FFFF);
        send_cmd(ksb_pkg::CMD_DEQ, 3'd0, 32'hFFFF_FFFF);
        send_cmd(ksb_pkg::CMD_DEQ, 3'd0, 32'h0000_0000);
        send_cmd(ksb_pkg::CMD_DEQ, 3'd0, $urandom());
        send_cmd(ksb_pkg::CMD_DEQ, 3'd7, $urandom());
        send_cmd(ksb_pkg::CMD_DEQ, 3'd7, $urandom());
        send_cmd(ksb_pkg::CMD_DEQ, 3'd7, $urandom());
        // Single-word queue, then reuse of freed slots in a different order.
        send_cmd(ksb_pkg::CMD_ENQ, 3'd3, 32'h5555_5555);
        send_cmd(ksb_pkg::CMD_DEQ, 3'd3, $urandom());
        send_cmd(ksb_pkg::CMD_ENQ, 3'd3, 32'hAAAA_AAAA);
        send_cmd(ksb_pkg::CMD_ENQ, 3'd5, 32'h1234_5678);
        send_cmd(ksb_pkg::CMD_ENQ, 3'd3, 32'h0000_0001);
        send_cmd(ksb_pkg::CMD_DEQ, 3'd3, $urandom());
        send_cmd(ksb_pkg::CMD_DEQ, 3'd5, $urandom());
        send_cmd(ksb_pkg::CMD_DEQ, 3'd3, $urandom());
        send_cmd(ksb_pkg::CMD_DEQ, 3'd3, $urandom());
        send_cmd(ksb_pkg::CMD_DEQ, 3'd4, $urandom());

        // Let the block go fully idle once before the random traffic.
        wait_all_replies();

        // Fill the whole store and run past it, then drain it again.
        run_phase(MIX_FILL, 140);
        run_phase(MIX_DRAIN, 160);

        while (items_sent < RANDOM_ITEMS) begin
            mix = t_mix'($urandom_range(0, 3));
            run_phase(mix, $urandom_range(40, 120));
            if ($urandom_range(0, 3) == 0) wait_all_replies();
        end

        wait_all_replies();
        repeat (SETTLE) @(negedge i_clk);
        if (ledger.errors == 0 && ledger.outstanding() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
